>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock edge, off in reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication, off in reset.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`endif

>>> hw/rtl/pcom_pkg.sv
// Package for the polyhedron centre-of-mass block: widths, codes, beat types.
// Depends on nothing.
`default_nettype none
package pcom_pkg;
   localparam int MaxFaces = 4096;
   localparam int QDepth   = 2;
   localparam logic [1:0] StatusOk   = 2'd0;
   localparam logic [1:0] StatusZero = 2'd1;
   localparam logic [1:0] StatusOvf  = 2'd2;
   localparam logic signed [19:0] CenterMax = 20'sd524287;
   localparam logic signed [19:0] CenterMin = -20'sd524288;

   // face beat handed from front to back
   typedef struct packed {
      logic signed [11:0] ax, ay, az, bx, by, bz, cx, cy, cz;
      logic               last_face;
   } face_type;
endpackage
`default_nettype wire

>>> hw/rtl/pcom_front.sv
// Front: accepts face beats and queues them for the back end.
// Depends on pcom_pkg.
`default_nettype none
module pcom_front import pcom_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire face_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output face_type      head
);
   face_type  mem_ff [QDepth];
   logic      wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'(QDepth));
   assign empty = (cnt_ff == 2'd0);
   assign head  = mem_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

>>> hw/rtl/pcom_back.sv
// Back end: triple product, sums, and a restoring divider for the centre.
// Depends on pcom_pkg.
`default_nettype none
module pcom_back import pcom_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     valid,
   input  wire face_type face,
   output logic          take,
   output logic          idle,
   output logic          rsp_strobe,
   output logic signed [19:0] rsp_center_x,
   output logic signed [19:0] rsp_center_y,
   output logic signed [19:0] rsp_center_z,
   output logic signed [47:0] rsp_six_volume,
   output logic [1:0]   rsp_status
);
   typedef enum logic [6:0] {
      S_CROSS = 7'b0000001, S_DOT = 7'b0000010, S_MOM = 7'b0000100,
      S_ACC = 7'b0001000, S_DIV = 7'b0010000, S_FIX = 7'b0100000,
      S_OUT = 7'b1000000
   } state_type;
   state_type state_ff, state_in;

   face_type f_ff;
   logic signed [24:0] kx_ff, ky_ff, kz_ff;
   logic signed [36:0] v_ff;
   logic signed [63:0] mx_ff, my_ff, mz_ff;
   logic signed [47:0] vol_ff, sixv_ff;
   logic [12:0] cnt_ff;
   logic        ovf_ff;
   logic [1:0]  axis_ff;
   logic [6:0]  bit_ff;
   logic [63:0] rem_ff;
   logic [69:0] quo_ff;
   logic [47:0] vm_ff;
   logic        neg_ff;
   logic signed [19:0] c_ff [3];
   logic [1:0]  st_ff;
   logic        strobe_ff;

   assign take = (state_ff == S_CROSS) && valid;
   assign idle = (state_ff == S_CROSS);
   assign rsp_strobe     = strobe_ff;
   assign rsp_center_x   = c_ff[0];
   assign rsp_center_y   = c_ff[1];
   assign rsp_center_z   = c_ff[2];
   assign rsp_six_volume = sixv_ff;
   assign rsp_status     = st_ff;

   // per-face arithmetic, one multiplier layer per step
   logic signed [13:0] sx, sy, sz;
   logic signed [24:0] kx_in, ky_in, kz_in;
   logic signed [36:0] v_in;
   logic signed [50:0] mpx, mpy, mpz;
   logic signed [47:0] vol_sum;
   logic        acc_full, skip_div;
   logic signed [63:0] cur_p;
   logic [63:0] pm, rem_sh;
   logic [64:0] trial;
   always_comb begin
      sx = 14'(f_ff.ax) + 14'(f_ff.bx) + 14'(f_ff.cx);
      sy = 14'(f_ff.ay) + 14'(f_ff.by) + 14'(f_ff.cy);
      sz = 14'(f_ff.az) + 14'(f_ff.bz) + 14'(f_ff.cz);
      kx_in = 25'(f_ff.by) * 25'(f_ff.cz) - 25'(f_ff.bz) * 25'(f_ff.cy);
      ky_in = 25'(f_ff.bz) * 25'(f_ff.cx) - 25'(f_ff.bx) * 25'(f_ff.cz);
      kz_in = 25'(f_ff.bx) * 25'(f_ff.cy) - 25'(f_ff.by) * 25'(f_ff.cx);
      v_in  = 37'(f_ff.ax) * 37'(kx_ff) + 37'(f_ff.ay) * 37'(ky_ff)
              + 37'(f_ff.az) * 37'(kz_ff);
      mpx = 51'(sx) * 51'(v_ff);
      mpy = 51'(sy) * 51'(v_ff);
      mpz = 51'(sz) * 51'(v_ff);
      // decide on the sums as they stand after this face
      acc_full = (cnt_ff >= 13'(MaxFaces));
      vol_sum  = vol_ff + 48'(v_ff);
      skip_div = ovf_ff || acc_full || (vol_sum == 48'sd0);
      case (axis_ff)
         2'd0:    cur_p = mx_ff;
         2'd1:    cur_p = my_ff;
         default: cur_p = mz_ff;
      endcase
      pm     = cur_p[63] ? 64'(-cur_p) : 64'(cur_p);
      rem_sh = {rem_ff[62:0], quo_ff[69]};
      trial  = {1'b0, rem_sh} - {17'd0, vm_ff};
   end

   // rounding and saturation of the quotient q0*64+frac
   logic [69:0] q_mag;
   logic [64:0] twice_r;
   logic [22:0] q_r;
   logic signed [19:0] sat;
   always_comb begin
      q_mag   = quo_ff;
      twice_r = {rem_ff, 1'b0};
      if (q_mag >= 70'd1 << 20) q_r = 23'd1 << 21;
      else q_r = 23'(q_mag) + ((twice_r >= {17'd0, vm_ff}) ? 23'd1 : 23'd0);
      if (neg_ff) sat = (q_r > 23'd524288) ? CenterMin : 20'(-$signed({1'b0, q_r}));
      else sat = (q_r > 23'd524287) ? CenterMax : 20'(q_r);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CROSS: if (valid) state_in = S_DOT;
         S_DOT:   state_in = S_MOM;
         S_MOM:   state_in = S_ACC;
         S_ACC:   state_in = f_ff.last_face ? (skip_div ? S_OUT : S_DIV) : S_CROSS;
         S_DIV:   if (bit_ff == 7'd1) state_in = S_FIX;
         S_FIX:   state_in = (axis_ff == 2'd2) ? S_OUT : S_DIV;
         S_OUT:   state_in = S_CROSS;
         default: state_in = S_CROSS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CROSS;
         strobe_ff <= 1'b0;
         mx_ff <= '0; my_ff <= '0; mz_ff <= '0; vol_ff <= '0;
         cnt_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == S_OUT);
         case (state_ff)
            S_CROSS: if (valid) f_ff <= face;
            S_DOT: begin
               kx_ff <= kx_in;
               ky_ff <= ky_in;
               kz_ff <= kz_in;
            end
            S_MOM: v_ff <= v_in;
            S_ACC: begin
               if (acc_full) ovf_ff <= 1'b1;
               else begin
                  mx_ff  <= mx_ff + 64'(mpx);
                  my_ff  <= my_ff + 64'(mpy);
                  mz_ff  <= mz_ff + 64'(mpz);
                  vol_ff <= vol_sum;
                  cnt_ff <= cnt_ff + 13'd1;
               end
               axis_ff <= 2'd0;
               bit_ff  <= 7'd127;
            end
            // divider: load on entry, then one quotient bit a cycle
            S_DIV: begin
               if (bit_ff == 7'd127) begin
                  quo_ff <= {pm, 6'd0};
                  rem_ff <= 64'd0;
                  vm_ff  <= vol_ff[47] ? 48'(-vol_ff) : 48'(vol_ff);
                  neg_ff <= cur_p[63] ^ vol_ff[47];
                  bit_ff <= 7'd70;
               end else begin
                  quo_ff <= {quo_ff[68:0], ~trial[64]};
                  rem_ff <= trial[64] ? rem_sh : trial[63:0];
                  bit_ff <= bit_ff - 7'd1;
               end
            end
            S_FIX: begin
               c_ff[axis_ff] <= sat;
               axis_ff <= axis_ff + 2'd1;
               bit_ff  <= 7'd127;
            end
            S_OUT: begin
               st_ff <= ovf_ff ? StatusOvf : (vol_ff == 48'sd0) ? StatusZero : StatusOk;
               sixv_ff <= vol_ff;
               if (ovf_ff || vol_ff == 48'sd0) begin
                  c_ff[0] <= 20'sd0; c_ff[1] <= 20'sd0; c_ff[2] <= 20'sd0;
               end
               mx_ff <= '0; my_ff <= '0; mz_ff <= '0; vol_ff <= '0;
               cnt_ff <= '0; ovf_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/polyhedron_center_of_mass.sv
// Top level of the polyhedron centre-of-mass block.
// Depends on pcom_pkg, pcom_front, pcom_back, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Usage: a face beat is taken when start is high and busy is low. The front
// queue holds two faces; busy rises when it is full. Each face passes through
// four back-end steps (cross, dot, moment, accumulate), and the back-end
// sequencer takes a new face only in the cross step.
// A face with req_last_face high ends the mesh: three centre divisions follow,
// each an operand load, 70 quotient bits in the bit-serial restoring divider
// and rounding, then one result beat with rsp_strobe high for one cycle.
// Zero volume or overflow skip division.
// The receiver cannot stall; every result is taken in its strobe cycle.
// Synchronous reset empties the queue and clears all sums.
module polyhedron_center_of_mass import pcom_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  wire logic signed [11:0] req_ax, req_ay, req_az,
   input  wire logic signed [11:0] req_bx, req_by, req_bz,
   input  wire logic signed [11:0] req_cx, req_cy, req_cz,
   input  wire logic req_last_face,
   output logic      rsp_strobe,
   output logic signed [19:0] rsp_center_x,
   output logic signed [19:0] rsp_center_y,
   output logic signed [19:0] rsp_center_z,
   output logic signed [47:0] rsp_six_volume,
   output logic [1:0] rsp_status
);
   face_type pd, head;
   logic full, empty, take, idle;
   assign pd = '{req_ax, req_ay, req_az, req_bx, req_by, req_bz,
                 req_cx, req_cy, req_cz, req_last_face};
   assign busy = full;

   pcom_front u_front (.clock, .reset, .push(start && !full), .push_data(pd),
      .full, .pop(take), .empty, .head);

   pcom_back u_back (.clock, .reset, .valid(!empty), .face(head), .take, .idle,
      .rsp_strobe, .rsp_center_x, .rsp_center_y, .rsp_center_z,
      .rsp_six_volume, .rsp_status);

   `ASSERT_IMPL(a_take_idle, clock, reset, take, idle && !empty, "pop while not idle")
   `ASSERT_NEXT(a_strobe_one, clock, reset, rsp_strobe, !rsp_strobe, "strobe longer than one")
   `ASSERT_IMPL(a_status_ok, clock, reset, rsp_strobe, rsp_status != 2'd3, "bad status")
endmodule
`default_nettype wire

>>> verif/polyhedron_center_of_mass_tb.sv
// Testbench for polyhedron_center_of_mass: streams mesh faces, predicts the centre and volume.
// Depends on pcom_pkg and the polyhedron_center_of_mass RTL.
`timescale 1ns / 100ps
`default_nettype none
module polyhedron_center_of_mass_tb;
   import pcom_pkg::*;

   typedef struct {
      logic signed [19:0] cx, cy, cz;
      logic signed [47:0] vol;
      logic [1:0]         status;
   } centre_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [11:0] req_ax = '0, req_ay = '0, req_az = '0;
   logic signed [11:0] req_bx = '0, req_by = '0, req_bz = '0;
   logic signed [11:0] req_cx = '0, req_cy = '0, req_cz = '0;
   logic req_last_face = 1'b0;
   logic rsp_strobe;
   logic signed [19:0] rsp_center_x, rsp_center_y, rsp_center_z;
   logic signed [47:0] rsp_six_volume;
   logic [1:0] rsp_status;

   // predicted mesh sums
   longint mom_x, mom_y, mom_z, vol_acc;
   int     faces_taken;
   bit     too_many;
   centre_type centres_due[$];
   int     errors = 0;

   polyhedron_center_of_mass dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // round(p*64/v), ties away from zero, saturated to 20 bits
   function automatic logic signed [19:0] centre_of(longint p, longint v);
      longint unsigned pm, vm, q0, r0, t, r1, q;
      bit neg;
      pm  = p < 0 ? -p : p;
      vm  = v < 0 ? -v : v;
      neg = (p < 0) != (v < 0);
      q0  = pm / vm;
      r0  = pm % vm;
      if (q0 >= 64'd16384) q = 64'd1 << 21;
      else begin
         t  = r0 * 64;
         r1 = t % vm;
         q  = q0 * 64 + t / vm;
         if (r1 >= vm - r1) q = q + 1;
      end
      if (neg) return (q > 64'd524288) ? CenterMin : -$signed(q[20:0]);
      return (q > 64'd524287) ? CenterMax : q[19:0];
   endfunction

   task automatic predict_face(input logic signed [11:0] f[9], input bit last);
      longint a[9], kx, ky, kz, v;
      centre_type e;
      foreach (f[i]) a[i] = f[i];
      if (faces_taken >= MaxFaces) too_many = 1;
      else begin
         kx = a[4] * a[8] - a[5] * a[7];
         ky = a[5] * a[6] - a[3] * a[8];
         kz = a[3] * a[7] - a[4] * a[6];
         v  = a[0] * kx + a[1] * ky + a[2] * kz;
         mom_x += (a[0] + a[3] + a[6]) * v;
         mom_y += (a[1] + a[4] + a[7]) * v;
         mom_z += (a[2] + a[5] + a[8]) * v;
         vol_acc += v;
         faces_taken++;
      end
      if (!last) return;
      e.status = too_many ? StatusOvf : (vol_acc == 0 ? StatusZero : StatusOk);
      e.cx = '0; e.cy = '0; e.cz = '0;
      if (e.status == StatusOk) begin
         e.cx = centre_of(mom_x, vol_acc);
         e.cy = centre_of(mom_y, vol_acc);
         e.cz = centre_of(mom_z, vol_acc);
      end
      e.vol = vol_acc[47:0];
      centres_due.push_back(e);
      mom_x = 0; mom_y = 0; mom_z = 0; vol_acc = 0; faces_taken = 0; too_many = 0;
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      repeat (n) @(posedge clock);
   endtask

   // one face beat: held until busy is low at an edge
   task automatic send_face(input logic signed [11:0] f[9], input bit last, input bit gaps);
      if (gaps && $urandom_range(0, 1)) begin
         start <= 1'b0;
         @(posedge clock);
         idle_gap();
      end
      start <= 1'b1;
      {req_ax, req_ay, req_az, req_bx, req_by, req_bz, req_cx, req_cy, req_cz} <=
         {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]};
      req_last_face <= last;
      do @(posedge clock); while (busy);
      predict_face(f, last);
   endtask

   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (centres_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [11:0] rnd12(int lim);
      return $signed(12'($urandom_range(0, 2 * lim) - lim));
   endfunction

   // closed tetrahedron of four random vertices, optionally with idle gaps
   task automatic send_tetra(input int lim, input bit gaps);
      logic signed [11:0] p[4][3], f[9];
      int idx[4][3] = '{'{0, 2, 1}, '{0, 1, 3}, '{0, 3, 2}, '{1, 2, 3}};
      foreach (p[i, j]) p[i][j] = rnd12(lim);
      for (int k = 0; k < 4; k++) begin
         for (int j = 0; j < 3; j++)
            for (int c = 0; c < 3; c++) f[j * 3 + c] = p[idx[k][j]][c];
         send_face(f, k == 3, gaps);
      end
   endtask

   task automatic test_directed();
      logic signed [11:0] f[9];
      // unit-ish tetrahedron, positive volume
      f = '{0, 0, 0, 100, 0, 0, 0, 100, 0};
      send_face(f, 0, 0);
      f = '{0, 0, 0, 0, 100, 0, 0, 0, 100};
      send_face(f, 0, 0);
      f = '{100, 0, 0, 0, 100, 0, 0, 0, 100};
      send_face(f, 1, 0);
      // zero volume
      f = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_face(f, 1, 0);
      // field extremes, mixed signs
      f = '{-2048, -2048, -2048, 2047, -2048, 2047, -2048, 2047, 2047};
      send_face(f, 1, 0);
      f = '{2047, 2047, 2047, -2048, 2047, -2048, 2047, -2048, -2048};
      send_face(f, 1, 0);
      // tiny volume, big moment
      f = '{1, 0, 0, 0, 1, 0, 2047, 2047, 1};
      send_face(f, 1, 0);
      f = '{-1, 0, 0, 0, 1, 0, -2048, -2048, 1};
      send_face(f, 1, 0);
      // cancelling pair gives zero volume
      f = '{5, 0, 0, 0, 5, 0, 0, 0, 5};
      send_face(f, 0, 0);
      f = '{5, 0, 0, 0, 0, 5, 0, 5, 0};
      send_face(f, 1, 0);
      quiesce();
   endtask

   task automatic test_random_meshes();
      logic signed [11:0] f[9];
      for (int m = 0; m < 370; m++) begin
         if ($urandom_range(0, 3) == 0) begin
            for (int k = $urandom_range(1, 6); k > 0; k--) begin
               foreach (f[i]) f[i] = rnd12(2048 >> $urandom_range(0, 8));
               if ($urandom_range(0, 1))
                  f[$urandom_range(0, 8)] = $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
               send_face(f, k == 1, 1);
            end
         end else send_tetra(2048 >> $urandom_range(0, 10), 1);
         if (m == 185) quiesce();
      end
      quiesce();
   endtask

   // one long mesh of full-range faces, back to back
   task automatic test_long_mesh();
      logic signed [11:0] f[9];
      for (int k = 0; k < 200; k++) begin
         foreach (f[i]) f[i] = rnd12(2047);
         send_face(f, k == 199, 0);
      end
      quiesce();
   endtask

   // result checker
   always @(posedge clock) begin
      centre_type e;
      if (!reset && rsp_strobe) begin
         if (centres_due.size() == 0) begin
            $error("result beat with none expected");
            errors++;
         end else begin
            e = centres_due.pop_front();
            if (rsp_center_x !== e.cx) begin
               $error("center_x exp %0d got %0d", e.cx, rsp_center_x); errors++;
            end
            if (rsp_center_y !== e.cy) begin
               $error("center_y exp %0d got %0d", e.cy, rsp_center_y); errors++;
            end
            if (rsp_center_z !== e.cz) begin
               $error("center_z exp %0d got %0d", e.cz, rsp_center_z); errors++;
            end
            if (rsp_six_volume !== e.vol) begin
               $error("six_volume exp %0d got %0d", e.vol, rsp_six_volume); errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++;
            end
         end
      end
   end

   initial begin
      mom_x = 0; mom_y = 0; mom_z = 0; vol_acc = 0; faces_taken = 0; too_many = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_meshes();
      test_long_mesh();
      repeat (400) @(posedge clock);
      if (errors == 0 && centres_due.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #(12 * 2500000);
      $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pcom_pkg.sv
hw/rtl/pcom_front.sv
hw/rtl/pcom_back.sv
hw/rtl/polyhedron_center_of_mass.sv
verif/polyhedron_center_of_mass_tb.sv
